// File: src/bsqr_pkg.sv
// Shared constants and controller/datapath interface types for the bisection square root unit.
`default_nettype none
package bsqr_pkg;

  // Q16.16 data width and the exact Q32.32 square width
  localparam int DATA_W = 32;
  localparam int SQ_W   = 64;
  localparam int FRAC_W = 16;

  // Iteration count field holds 0..127
  localparam int ITER_W = 7;

  localparam int MAX_ITERATIONS_DEF = 48;

  // 1.0 in Q16.16 and the tolerance reset value (about 0.1)
  localparam logic [DATA_W-1:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [DATA_W-1:0] TOL_RESET = 32'd6554;

  // Configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_TOLERANCE = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // take a new item and set up the interval
    logic square;   // square the current midpoint
    logic iterate;  // move one bound and take the new midpoint
    logic capture;  // copy the finished result to the output registers
  } bsqr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic stop;     // search ends at the current midpoint
  } bsqr_sts_t;

endpackage
`default_nettype wire

// File: src/bsqr_datapath.sv
// Datapath: interval bounds, shared squarer, error compare and result registers.
`default_nettype none
module bsqr_datapath #(
  parameter int MAX_ITERATIONS = bsqr_pkg::MAX_ITERATIONS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bsqr_pkg::bsqr_cmd_t                cmd,
  output bsqr_pkg::bsqr_sts_t                     sts,
  input  wire logic [bsqr_pkg::DATA_W-1:0]        value,
  input  wire logic [bsqr_pkg::DATA_W-1:0]        tolerance,
  output logic      [bsqr_pkg::DATA_W-1:0]        root,
  output logic      [bsqr_pkg::ITER_W-1:0]        iterations,
  output logic                                    converged
);

  localparam logic [bsqr_pkg::ITER_W-1:0] ITER_CAP = bsqr_pkg::ITER_W'(MAX_ITERATIONS);

  logic [bsqr_pkg::DATA_W-1:0] v;
  logic [bsqr_pkg::DATA_W-1:0] lo;
  logic [bsqr_pkg::DATA_W-1:0] hi;
  logic [bsqr_pkg::DATA_W-1:0] x;
  logic [bsqr_pkg::SQ_W-1:0]   sq;
  logic [bsqr_pkg::ITER_W-1:0] steps;
  logic                        special;

  logic [bsqr_pkg::SQ_W-1:0]   target;
  logic [bsqr_pkg::SQ_W-1:0]   tol_wide;
  logic [bsqr_pkg::SQ_W-1:0]   err;
  logic                        below;
  logic                        in_tol;
  logic [bsqr_pkg::DATA_W:0]   sum_up;
  logic [bsqr_pkg::DATA_W:0]   sum_dn;
  logic [bsqr_pkg::DATA_W-1:0] hi_load;

  // Compare the square with v, both in Q32.32
  assign target   = {16'd0, v, {bsqr_pkg::FRAC_W{1'b0}}};
  assign tol_wide = {16'd0, tolerance, {bsqr_pkg::FRAC_W{1'b0}}};
  assign below    = sq < target;
  assign err      = below ? (target - sq) : (sq - target);
  assign in_tol   = err <= tol_wide;

  // Candidate midpoints for either bound move
  assign sum_up = {1'b0, x} + {1'b0, hi};
  assign sum_dn = {1'b0, lo} + {1'b0, x};

  assign hi_load = (value >= bsqr_pkg::ONE_Q16) ? value : bsqr_pkg::ONE_Q16;

  assign sts.stop = special || in_tol || (steps == ITER_CAP);

  // Interval registers and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      lo      <= '0;
      hi      <= '0;
      x       <= '0;
      steps   <= '0;
      special <= 1'b0;
    end else if (cmd.load) begin
      v       <= value;
      lo      <= '0;
      hi      <= hi_load;
      x       <= (value == '0 || value == bsqr_pkg::ONE_Q16) ? value : (hi_load >> 1);
      steps   <= '0;
      special <= (value == '0) || (value == bsqr_pkg::ONE_Q16);
    end else if (cmd.iterate) begin
      if (below) begin
        lo <= x;
        x  <= sum_up[bsqr_pkg::DATA_W:1];
      end else begin
        hi <= x;
        x  <= sum_dn[bsqr_pkg::DATA_W:1];
      end
      steps <= steps + 1'b1;
    end
  end

  // Square the midpoint, one multiply per step
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq <= {32'd0, x} * {32'd0, x};
    end
  end

  // Hold the finished result for the output side
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      root       <= x;
      iterations <= steps;
      converged  <= special || in_tol;
    end
  end

  a_steps_capped : assert property (@(posedge clk) disable iff (rst)
    steps <= ITER_CAP)
    else $error("step count passed the cap");

  a_mid_in_interval : assert property (@(posedge clk) disable iff (rst)
    (lo <= x) && (x <= hi))
    else $error("midpoint left the interval");

  a_step_counts : assert property (@(posedge clk) disable iff (rst)
    cmd.iterate |=> steps == $past(steps) + 1'b1)
    else $error("iterate did not advance the step count");

endmodule
`default_nettype wire

// File: src/bsqr_controller.sv
// Controller: sequences load, square and compare steps and owns the item handshakes.
`default_nettype none
module bsqr_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bsqr_pkg::bsqr_cmd_t      cmd,
  input  wire bsqr_pkg::bsqr_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.square = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.stop) begin
          if (out_free) begin
            cmd.capture = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.iterate = 1'b1;
          state_next  = S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on capture, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_capture_free : assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> out_free)
    else $error("result captured over a waiting item");

  a_capture_shows : assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> out_valid && state == S_IDLE)
    else $error("captured result not presented");

  a_single_cmd : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.square, cmd.iterate, cmd.capture}))
    else $error("more than one datapath command");

endmodule
`default_nettype wire

// File: src/bisection_square_root_unit.sv
// Top level of the bisection square root unit: configuration port, controller and datapath.
//
// Takes one unsigned Q16.16 value at a time and returns its square root by halving the
// interval [0, max(1, v)] until the midpoint's square lies within the tolerance register of
// v or MAX_ITERATIONS halving steps are taken. Each step squares the midpoint on the shared
// 32x32 multiplier in the S_MUL state, then does the exact Q32.32 error compare that moves
// a bound in the S_CMP state. Values 0 and 1.0 take no halving steps. The next item is
// taken once the current one has been moved to the output register.
`default_nettype none
module bisection_square_root_unit #(
  parameter int MAX_ITERATIONS = bsqr_pkg::MAX_ITERATIONS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bsqr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [bsqr_pkg::DATA_W-1:0]         value,
  // result items
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [bsqr_pkg::DATA_W-1:0]         root,
  output logic      [bsqr_pkg::ITER_W-1:0]         iterations,
  output logic                                     converged
);

  logic [bsqr_pkg::DATA_W-1:0] tolerance;
  bsqr_pkg::bsqr_cmd_t         cmd;
  bsqr_pkg::bsqr_sts_t         sts;

  assign pready = 1'b1;

  // Tolerance register write
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= bsqr_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == bsqr_pkg::REG_TOLERANCE) begin
      tolerance <= pwdata;
    end
  end

  // Register read back
  assign prdata = (paddr[2] == bsqr_pkg::REG_TOLERANCE) ? tolerance : '0;

  bsqr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bsqr_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .tolerance  (tolerance),
    .root       (root),
    .iterations (iterations),
    .converged  (converged)
  );

endmodule
`default_nettype wire
